// ===== rtl/core/tcf_pkg.sv =====
// Shared types and constants for the tilt complementary filter.
// No dependencies.
package tcf_pkg;

    localparam int TAB_LEN = 24;
    localparam int SAMPLE_W = 16;

    // Arctangent of 2^-i in degrees, 20 fraction bits.
    function automatic logic [26:0] atan_tab(input logic [4:0] idx);
        logic [26:0] v;
        begin
            case (idx)
                5'd0: v = 27'd47185920;
                5'd1: v = 27'd27855475;
                5'd2: v = 27'd14718068;
                5'd3: v = 27'd7471121;
                5'd4: v = 27'd3750058;
                5'd5: v = 27'd1876857;
                5'd6: v = 27'd938658;
                5'd7: v = 27'd469357;
                5'd8: v = 27'd234682;
                5'd9: v = 27'd117342;
                5'd10: v = 27'd58671;
                5'd11: v = 27'd29335;
                5'd12: v = 27'd14668;
                5'd13: v = 27'd7334;
                5'd14: v = 27'd3667;
                5'd15: v = 27'd1833;
                5'd16: v = 27'd917;
                5'd17: v = 27'd458;
                5'd18: v = 27'd229;
                5'd19: v = 27'd115;
                5'd20: v = 27'd57;
                5'd21: v = 27'd29;
                5'd22: v = 27'd14;
                5'd23: v = 27'd7;
                default: v = 27'd0;
            endcase
            return v;
        end
    endfunction

    // Register indexes.
    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_GAIN = 1'b1;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;      // capture the input sample
        logic sq_step;   // one square-root bit step
        logic cor_init;  // set up the CORDIC
        logic cor_step;  // one CORDIC rotation
        logic fuse_mul;  // first fusion product
        logic fuse_fin;  // second product and update
    } tcf_cmd_t;

endpackage

// ===== rtl/core/tcf_sample_if.sv =====
// Handshake interface carrying one sensor sample set.
// Depends on nothing.
interface tcf_sample_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    modport source (output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, input ready);
    modport sink (input valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, output ready);
endinterface

// ===== rtl/core/tcf_angle_if.sv =====
// Handshake interface carrying one fused angle pair.
// Depends on nothing.
interface tcf_angle_if;
    logic              valid;
    logic              ready;
    logic signed [17:0] angle_x;
    logic signed [17:0] angle_y;
    modport source (output valid, angle_x, angle_y, input ready);
    modport sink (input valid, angle_x, angle_y, output ready);
endinterface

// ===== rtl/core/tcf_ctrl.sv =====
// Controller state machine sequencing square root, CORDIC and fusion.
// Depends on tcf_pkg.
module tcf_ctrl
    import tcf_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output tcf_cmd_t cmd,
    output logic [4:0] step
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQRT = 6'b000010,
        S_CINI = 6'b000100,
        S_CORD = 6'b001000,
        S_FMUL = 6'b010000,
        S_FFIN = 6'b100000
    } state_t;

    localparam int NSTEP = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;

    state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    // Input is taken when idle and the previous result has been taken.
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign step = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    cnt_next = 5'd0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sq_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    state_next = S_CINI;
                end
            end
            S_CINI:
            begin
                cmd.cor_init = 1'b1;
                cnt_next = 5'd0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                cmd.cor_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(NSTEP - 1))
                begin
                    state_next = S_FMUL;
                end
            end
            S_FMUL:
            begin
                cmd.fuse_mul = 1'b1;
                state_next = S_FFIN;
            end
            S_FFIN:
            begin
                cmd.fuse_fin = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is never raised while one is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped");
    // No sample is taken while work is in progress.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("ready while busy");
    // The update command is followed by a visible result.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fuse_fin |=> out_valid_reg)
        else $error("missing result");
endmodule

// ===== rtl/core/tcf_datapath.sv =====
// Datapath: two bit-serial square roots, two CORDIC vectoring units and fusion.
// Depends on tcf_pkg.
module tcf_datapath
    import tcf_pkg::*;
#(
    parameter int FRAC = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tcf_cmd_t           cmd,
    input  logic [4:0]         step,
    input  logic signed [15:0] acc_x,
    input  logic signed [15:0] acc_y,
    input  logic signed [15:0] acc_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic [15:0]        alpha,
    input  logic [15:0]        gain,
    output logic [17:0]        angle_x,
    output logic [17:0]        angle_y
);
    localparam int UPS = 24 - FRAC;
    localparam int ACC_SH = 20 - FRAC;
    localparam int OUT_SH = 40 - FRAC;
    localparam int EST_W = 10 + FRAC;
    localparam logic signed [63:0] LIM = 64'sd360 <<< FRAC;

    logic signed [15:0] ax_reg, ay_reg, gx_reg, gy_reg;
    // Square root state: remainder, root and radicand for each axis pair.
    logic [31:0] rad_a_reg, rad_b_reg;
    logic [33:0] rem_a_reg, rem_b_reg;
    logic [16:0] root_a_reg, root_b_reg;
    // CORDIC registers.
    logic signed [40:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic signed [31:0] za_reg, zb_reg;
    logic nz_a_reg, nz_b_reg;
    logic signed [EST_W-1:0] roll_reg, pitch_reg;
    logic signed [34:0] pr_a_reg, pr_b_reg;
    logic signed [63:0] ac_a_reg, ac_b_reg;

    logic [33:0] trial_a, trial_b, rem_a_sh, rem_b_sh;
    logic signed [31:0] tab_v;
    logic signed [31:0] acc_a, acc_b;
    logic signed [32:0] gp_a, gp_b;
    logic signed [34:0] pd_a, pd_b;
    logic signed [49:0] ap_a, ap_b;
    logic signed [51:0] wp_a, wp_b;
    logic signed [63:0] bl_a, bl_b, r_a, r_b;
    logic [16:0] beta;

    // Restoring square root, one result bit per step.
    assign rem_a_sh = {rem_a_reg[31:0], rad_a_reg[31:30]};
    assign rem_b_sh = {rem_b_reg[31:0], rad_b_reg[31:30]};
    assign trial_a = {root_a_reg[15:0], 2'b01};
    assign trial_b = {root_b_reg[15:0], 2'b01};

    assign tab_v = signed'({5'd0, atan_tab(step)});

    // Accel angle rounding and the first fusion products.
    assign acc_a = (za_reg + (32'sd1 <<< (ACC_SH - 1))) >>> ACC_SH;
    assign acc_b = (zb_reg + (32'sd1 <<< (ACC_SH - 1))) >>> ACC_SH;
    assign beta = 17'd65536 - {1'b0, alpha};
    assign gp_a = gx_reg * signed'({1'b0, gain});
    assign gp_b = gy_reg * signed'({1'b0, gain});
    assign pd_a = (35'(roll_reg) <<< UPS) + 35'(gp_a);
    assign pd_b = (35'(pitch_reg) <<< UPS) + 35'(gp_b);
    assign ap_a = acc_a * signed'({1'b0, beta});
    assign ap_b = acc_b * signed'({1'b0, beta});

    // Second stage: the prediction weighted by alpha joins the accel term.
    assign wp_a = pr_a_reg * signed'({1'b0, alpha});
    assign wp_b = pr_b_reg * signed'({1'b0, alpha});
    assign bl_a = 64'(wp_a) + ac_a_reg;
    assign bl_b = 64'(wp_b) + ac_b_reg;
    assign r_a = (bl_a + (64'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;
    assign r_b = (bl_b + (64'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;

    function automatic logic signed [EST_W-1:0] sat(input logic signed [63:0] v);
        logic signed [63:0] t;
        begin
            t = v;
            if (v > LIM) t = LIM;
            if (v < -LIM) t = -LIM;
            return EST_W'(t);
        end
    endfunction

    // Estimates live in control-reset registers; the rest is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg <= '0;
            pitch_reg <= '0;
        end
        else if (cmd.fuse_fin)
        begin
            roll_reg <= sat(r_a);
            pitch_reg <= sat(r_b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= acc_x;
            ay_reg <= acc_y;
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
            rad_a_reg <= 32'(acc_x * acc_x) + 32'(acc_z * acc_z);
            rad_b_reg <= 32'(acc_y * acc_y) + 32'(acc_z * acc_z);
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            root_a_reg <= '0;
            root_b_reg <= '0;
        end
        if (cmd.sq_step)
        begin
            rad_a_reg <= {rad_a_reg[29:0], 2'b00};
            rad_b_reg <= {rad_b_reg[29:0], 2'b00};
            if (rem_a_sh >= trial_a)
            begin
                rem_a_reg <= rem_a_sh - trial_a;
                root_a_reg <= {root_a_reg[15:0], 1'b1};
            end
            else
            begin
                rem_a_reg <= rem_a_sh;
                root_a_reg <= {root_a_reg[15:0], 1'b0};
            end
            if (rem_b_sh >= trial_b)
            begin
                rem_b_reg <= rem_b_sh - trial_b;
                root_b_reg <= {root_b_reg[15:0], 1'b1};
            end
            else
            begin
                rem_b_reg <= rem_b_sh;
                root_b_reg <= {root_b_reg[15:0], 1'b0};
            end
        end
        // Roll: atan2(ay, rxz); pitch: atan2(-ax, ryz).
        if (cmd.cor_init)
        begin
            xa_reg <= signed'({12'd0, root_a_reg, 12'd0});
            ya_reg <= 41'(ay_reg) <<< 12;
            xb_reg <= signed'({12'd0, root_b_reg, 12'd0});
            yb_reg <= -(41'(ax_reg) <<< 12);
            za_reg <= '0;
            zb_reg <= '0;
            nz_a_reg <= ay_reg != 16'sd0;
            nz_b_reg <= ax_reg != 16'sd0;
        end
        if (cmd.cor_step)
        begin
            if (!ya_reg[40])
            begin
                xa_reg <= xa_reg + (ya_reg >>> step);
                ya_reg <= ya_reg - (xa_reg >>> step);
                za_reg <= za_reg + tab_v;
            end
            else
            begin
                xa_reg <= xa_reg - (ya_reg >>> step);
                ya_reg <= ya_reg + (xa_reg >>> step);
                za_reg <= za_reg - tab_v;
            end
            if (!yb_reg[40])
            begin
                xb_reg <= xb_reg + (yb_reg >>> step);
                yb_reg <= yb_reg - (xb_reg >>> step);
                zb_reg <= zb_reg + tab_v;
            end
            else
            begin
                xb_reg <= xb_reg - (yb_reg >>> step);
                yb_reg <= yb_reg + (xb_reg >>> step);
                zb_reg <= zb_reg - tab_v;
            end
        end
        // Prediction and up-scaled accel term, each under one multiply.
        if (cmd.fuse_mul)
        begin
            pr_a_reg <= pd_a;
            pr_b_reg <= pd_b;
            ac_a_reg <= nz_a_reg ? (64'(ap_a) <<< UPS) : 64'sd0;
            ac_b_reg <= nz_b_reg ? (64'(ap_b) <<< UPS) : 64'sd0;
        end
    end

    assign angle_x = 18'(roll_reg);
    assign angle_y = 18'(pitch_reg);
endmodule

// ===== rtl/core/tilt_complementary_filter_unit.sv =====
// Tilt complementary filter top level. From the input transfer to the result the controller runs
// the bit-serial square root steps, the CORDIC set-up, CORDIC_STEPS rotations (at most TAB_LEN)
// on the two CORDIC vectoring units, the fusion multiply and the update; one item at a time, so a
// new input is taken only once the previous result has gone.
// Reset (rst_n, asynchronous) clears both estimates and loads the default gains.
// Depends on tcf_pkg, tcf_sample_if, tcf_angle_if, tcf_ctrl and tcf_datapath.
module tilt_complementary_filter_unit
    import tcf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_FRAC_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    tcf_sample_if.sink  in_ch,
    tcf_angle_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] alpha_reg, gain_reg;
    tcf_cmd_t cmd;
    logic [4:0] step;
    logic wr;

    // Register file write.
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 16'd64225;
            gain_reg <= 16'd1281;
        end
        else if (wr)
        begin
            if (paddr[2] == REG_ALPHA)
            begin
                alpha_reg <= pwdata[15:0];
            end
            else
            begin
                gain_reg <= pwdata[15:0];
            end
        end
    end
    assign prdata = {16'd0, (paddr[2] == REG_GAIN) ? gain_reg : alpha_reg};

    tcf_ctrl #(.STEPS(CORDIC_STEPS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .step(step)
    );

    tcf_datapath #(.FRAC(ANGLE_FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .step(step),
        .acc_x(in_ch.acc_x), .acc_y(in_ch.acc_y), .acc_z(in_ch.acc_z),
        .gyro_x(in_ch.gyro_x), .gyro_y(in_ch.gyro_y),
        .alpha(alpha_reg), .gain(gain_reg),
        .angle_x(out_ch.angle_x), .angle_y(out_ch.angle_y)
    );
endmodule
